FILE: hdl/tgp_pkg.sv
// Package for the teleinformation group parser: widths, class codes, label table
// and the command word passed from the front end to the back end.
// No dependencies.
package tgp_pkg;

  localparam int LabelChars = 8;
  localparam int LabelIdxW  = $clog2(LabelChars);
  localparam int CharW      = 7;
  localparam int ClassW     = 4;
  localparam int ValueW     = 30;
  localparam int NumLabels  = 9;

  localparam logic [ValueW-1:0] ValueMax = ValueW'(999999999);
  localparam logic [ValueW-1:0] SatLimit = ValueW'(999999999 / 10);

  localparam logic [CharW-1:0] ChEtx   = 7'd3;
  localparam logic [CharW-1:0] ChTab   = 7'd9;
  localparam logic [CharW-1:0] ChLf    = 7'd10;
  localparam logic [CharW-1:0] ChVt    = 7'd11;
  localparam logic [CharW-1:0] ChFf    = 7'd12;
  localparam logic [CharW-1:0] ChCr    = 7'd13;
  localparam logic [CharW-1:0] ChSpace = 7'd32;
  localparam logic [CharW-1:0] ChZero  = 7'd48;
  localparam logic [CharW-1:0] ChNine  = 7'd57;

  localparam logic [ClassW-1:0] ClsOther  = 4'd0;
  localparam logic [ClassW-1:0] ClsEast   = 4'd1;
  localparam logic [ClassW-1:0] ClsEait   = 4'd2;
  localparam logic [ClassW-1:0] ClsSinsts = 4'd3;
  localparam logic [ClassW-1:0] ClsSinsti = 4'd4;
  localparam logic [ClassW-1:0] ClsDate   = 4'd5;
  localparam logic [ClassW-1:0] ClsUrms1  = 4'd6;
  localparam logic [ClassW-1:0] ClsIrms1  = 4'd7;
  localparam logic [ClassW-1:0] ClsLtarf  = 4'd8;
  localparam logic [ClassW-1:0] ClsStge   = 4'd9;

  // Labels padded with spaces to six characters; first character in the top byte.
  localparam logic [47:0] LabelText [NumLabels] = '{
    "EAST  ", "EAIT  ", "SINSTS", "SINSTI", "DATE  ",
    "URMS1 ", "IRMS1 ", "LTARF ", "STGE  "
  };
  localparam logic [2:0] LabelSize [NumLabels] = '{
    3'd4, 3'd4, 3'd6, 3'd6, 3'd4, 3'd5, 3'd5, 3'd5, 3'd4
  };
  localparam int ExactLabel = 2;

  typedef enum logic [1:0] {
    OpOpen  = 2'd0,
    OpChar  = 2'd1,
    OpClose = 2'd2
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [CharW-1:0] ch;
  } cmd_t;

  typedef logic [LabelChars-1:0][CharW-1:0] label_t;

endpackage

FILE: hdl/tgp_if.sv
// Handshake channels of the teleinformation group parser: input bytes and results.
// Depends on tgp_pkg for the field widths.
interface tgp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface tgp_result_if;
  logic                       valid;
  logic                       ready;
  logic [tgp_pkg::ClassW-1:0] label_class;
  logic [tgp_pkg::ValueW-1:0] field_value;
  logic                       check_done;
  logic                       check_ok;
  logic [tgp_pkg::CharW-1:0]  status_char;

  modport source (output valid, output label_class, output field_value,
                  output check_done, output check_ok, output status_char, input ready);
  modport sink (input valid, input label_class, input field_value,
                input check_done, input check_ok, input status_char, output ready);
endinterface

FILE: hdl/tgp_front.sv
// Front end: accepts bytes, tracks whether a group is open and turns bytes into
// open, character and close commands. Depends on tgp_pkg and tgp_if.
module tgp_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  tgp_byte_if.sink      in_i,
  output tgp_pkg::cmd_t cmd_o,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i
);
  import tgp_pkg::*;

  logic             in_group_q, in_group_d;
  logic [CharW-1:0] ch;
  logic             accept;

  assign ch        = in_i.rx_byte[CharW-1:0];
  assign in_i.ready = cmd_ready_i;
  assign accept    = in_i.valid && cmd_ready_i;

  always_comb begin
    in_group_d  = in_group_q;
    cmd_valid_o = 1'b0;
    cmd_o.op    = OpChar;
    cmd_o.ch    = ch;
    if (ch == ChLf) begin
      cmd_o.op    = OpOpen;
      cmd_valid_o = in_i.valid;
      in_group_d  = 1'b1;
    end else if (ch == ChEtx) begin
      in_group_d = 1'b0;
    end else if (in_group_q) begin
      cmd_valid_o = in_i.valid;
      if (ch == ChCr) begin
        cmd_o.op   = OpClose;
        in_group_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_group_q <= 1'b0;
    end else if (accept) begin
      in_group_q <= in_group_d;
    end
  end

endmodule

FILE: hdl/tgp_queue.sv
// Two-entry command queue between the front end and the back end.
// Depends on tgp_pkg.
module tgp_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tgp_pkg::cmd_t push_cmd_i,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  output tgp_pkg::cmd_t pop_cmd_o,
  output logic          pop_valid_o,
  input  logic          pop_ready_i
);
  import tgp_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_cmd_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

FILE: hdl/tgp_back.sv
// Back end: runs the group state on each command and registers one result per
// close command. Depends on tgp_pkg and tgp_if.
module tgp_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          tariff_from_server_i,
  input  tgp_pkg::cmd_t cmd_i,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  tgp_result_if.source  out_o
);
  import tgp_pkg::*;

  logic [1:0]        tab_q, tab_d;
  label_t            label_q, label_d;
  logic [3:0]        len_q, len_d;
  logic [ValueW-1:0] acc_q, acc_d;
  logic [1:0]        phase_q, phase_d;
  logic [5:0]        sum_q, sum_d;
  logic [CharW-1:0]  rc_q, rc_d;
  logic              have_q, have_d;
  logic [1:0]        cnt_q, cnt_d;
  logic [CharW-1:0]  second_q, second_d;

  logic              out_valid_q;
  logic [ClassW-1:0] cls_q, cls_d;
  logic [ValueW-1:0] val_q;
  logic              done_q, done_d;
  logic              ok_q, ok_d;
  logic [CharW-1:0]  stat_q, stat_d;

  logic [CharW-1:0]  c;
  logic              blank, digit, pop, is_close;
  logic [ValueW+3:0] acc_x10;
  logic [6:0]        computed;

  function automatic logic [ClassW-1:0] classify(input label_t lab, input logic [3:0] len);
    logic [ClassW-1:0] cls;
    logic              hit;
    logic              fits;
    cls = ClsOther;
    for (int i = NumLabels - 1; i >= 0; i--) begin
      hit = 1'b1;
      for (int j = 0; j < 6; j++) begin
        if (j < int'(LabelSize[i]) && lab[j] != LabelText[i][46-8*j -: CharW]) begin
          hit = 1'b0;
        end
      end
      fits = (i == ExactLabel) ? (len == {1'b0, LabelSize[i]}) : (len >= {1'b0, LabelSize[i]});
      if (hit && fits) cls = ClassW'(i + 1);
    end
    return cls;
  endfunction

  assign c        = cmd_i.ch;
  assign is_close = (cmd_i.op == OpClose);
  assign cmd_ready_o = !is_close || !out_valid_q || out_o.ready;
  assign pop      = cmd_valid_i && cmd_ready_o;
  assign blank    = (c == ChSpace) || (c == ChVt) || (c == ChFf) || (c == ChCr);
  assign digit    = (c >= ChZero) && (c <= ChNine);
  assign acc_x10  = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1)
                  + (ValueW+4)'(c - ChZero);

  always_comb begin
    tab_d    = tab_q;
    label_d  = label_q;
    len_d    = len_q;
    acc_d    = acc_q;
    phase_d  = phase_q;
    sum_d    = sum_q;
    rc_d     = rc_q;
    have_d   = have_q;
    cnt_d    = cnt_q;
    second_d = second_q;
    if (cmd_i.op == OpOpen) begin
      tab_d    = 2'd0;
      label_d  = '0;
      len_d    = 4'd0;
      acc_d    = '0;
      phase_d  = 2'd0;
      sum_d    = 6'd0;
      rc_d     = '0;
      have_d   = 1'b0;
      cnt_d    = 2'd0;
      second_d = '0;
    end else begin
      if (tab_q == 2'd2 && !have_q) begin
        rc_d   = c;
        have_d = 1'b1;
      end
      if (c == ChTab) begin
        if (tab_q != 2'd3) tab_d = tab_q + 2'd1;
      end else if (tab_q == 2'd0) begin
        if (32'(len_q) < LabelChars) label_d[len_q[LabelIdxW-1:0]] = c;
        if (len_q != 4'd15) len_d = len_q + 4'd1;
        sum_d = sum_q + c[5:0];
      end else if (tab_q == 2'd1) begin
        sum_d = sum_q + c[5:0];
        if (!(phase_q == 2'd0 && blank)) begin
          if (phase_q == 2'd0) begin
            phase_d = digit ? 2'd1 : 2'd2;
          end else if (phase_q == 2'd1 && !digit) begin
            phase_d = 2'd2;
          end
          if (phase_d == 2'd1) begin
            acc_d = (acc_q > SatLimit) ? ValueMax : acc_x10[ValueW-1:0];
          end
          if (cnt_q == 2'd0) begin
            cnt_d = 2'd1;
          end else if (cnt_q == 2'd1) begin
            second_d = c;
            cnt_d    = blank ? 2'd2 : 2'd3;
          end else if (cnt_q == 2'd2 && !blank) begin
            cnt_d = 2'd3;
          end
        end
      end
    end
  end

  always_comb begin
    cls_d = classify(label_d, len_d);
    if ((cls_d == ClsLtarf || cls_d == ClsStge) && tariff_from_server_i) cls_d = ClsOther;
    computed = {1'b0, sum_d + 6'd18} + 7'd32;
    done_d   = (cls_d >= ClsEast) && (cls_d <= ClsSinsti);
    ok_d     = have_d && (computed == rc_d);
    stat_d   = (cls_d == ClsStge && cnt_d == 2'd3) ? second_d : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tab_q    <= 2'd0;
      label_q  <= '0;
      len_q    <= 4'd0;
      acc_q    <= '0;
      phase_q  <= 2'd0;
      sum_q    <= 6'd0;
      rc_q     <= '0;
      have_q   <= 1'b0;
      cnt_q    <= 2'd0;
      second_q <= '0;
    end else if (pop) begin
      tab_q    <= tab_d;
      label_q  <= label_d;
      len_q    <= len_d;
      acc_q    <= acc_d;
      phase_q  <= phase_d;
      sum_q    <= sum_d;
      rc_q     <= rc_d;
      have_q   <= have_d;
      cnt_q    <= cnt_d;
      second_q <= second_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop && is_close) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && is_close) begin
      cls_q  <= cls_d;
      val_q  <= acc_d;
      done_q <= done_d;
      ok_q   <= ok_d;
      stat_q <= stat_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.label_class = cls_q;
  assign out_o.field_value = val_q;
  assign out_o.check_done  = done_q;
  assign out_o.check_ok    = ok_q;
  assign out_o.status_char = stat_q;

endmodule

FILE: hdl/tic_group_parser_checksum.sv
// Top level of the teleinformation group parser with checksum check.
// Depends on tgp_pkg, tgp_if, tgp_front, tgp_queue and tgp_back.
//
// Usage:
//   in_i carries one received character per word; bit 7 is ignored. A LF opens
//   a group, an ETX aborts it, and the CR that closes an open group yields one
//   result word on out_o: label class, decimal value, checksum verdict and the
//   status character of STGE groups. All other bytes yield no result.
//   cfg_we_i writes cfg_data_i into the tariff_from_server register; write it
//   only while the block is idle.
// Timing:
//   One byte is accepted per cycle while the queue has room. The front end
//   classifies the byte and puts a command into a two-entry queue; the back end
//   updates the group state one command per cycle unless a close command meets
//   an untaken result word. Each result word is registered and waits until taken.
//   When out_o stalls, characters keep flowing until a second CR reaches the
//   back end; then the queue fills and in_i.ready drops.
// Reset:
//   rst_ni clears the group state, the queue, the output register and the
//   tariff_from_server register.
module tic_group_parser_checksum (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_data_i,
  tgp_byte_if.sink     in_i,
  tgp_result_if.source out_o
);
  import tgp_pkg::*;

  logic tariff_q;
  cmd_t front_cmd, back_cmd;
  logic front_valid, front_ready, back_valid, back_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tariff_q <= 1'b0;
    end else if (cfg_we_i) begin
      tariff_q <= cfg_data_i;
    end
  end

  tgp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_o       (front_cmd),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready)
  );

  tgp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_cmd_i   (front_cmd),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_cmd_o    (back_cmd),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready)
  );

  tgp_back u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .tariff_from_server_i (tariff_q),
    .cmd_i                (back_cmd),
    .cmd_valid_i          (back_valid),
    .cmd_ready_o          (back_ready),
    .out_o                (out_o)
  );

endmodule

FILE: hdl/tgp_checker.sv
// Port-level checker for tic_group_parser_checksum, attached by a bind.
// Depends on tgp_pkg.
module tgp_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [tgp_pkg::ClassW-1:0] label_class_i,
  input logic [tgp_pkg::ValueW-1:0] field_value_i,
  input logic                       check_done_i,
  input logic [tgp_pkg::CharW-1:0]  status_char_i
);
  import tgp_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(label_class_i)
      && $stable(field_value_i))
    else $error("Stalled result word changed.");

  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> check_done_i == (label_class_i >= ClsEast && label_class_i <= ClsSinsti))
    else $error("Checksum flag does not match the label class.");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_char_i != '0 |-> label_class_i == ClsStge)
    else $error("Status character given for a label other than STGE.");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> field_value_i <= ValueMax && label_class_i <= ClsStge)
    else $error("Result field out of range.");

endmodule

bind tic_group_parser_checksum tgp_checker u_tgp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .label_class_i (out_o.label_class),
  .field_value_i (out_o.field_value),
  .check_done_i  (out_o.check_done),
  .status_char_i (out_o.status_char)
);

FILE: tb/sv/tb_tic_group_parser_checksum.sv
// Testbench for tic_group_parser_checksum: streams teleinformation bytes, predicts every
// group report and compares each result word field by field with the prediction.
// Depends on tgp_pkg, tgp_if and the RTL of the parser.
`timescale 1ns / 1ps

module tb_tic_group_parser_checksum;
  import tgp_pkg::*;

  localparam logic [7:0] ChStx     = 8'd2;
  localparam int         CheckBias = 18;
  localparam int         CheckBase = 32;
  localparam int         PhaseBytes = 200;
  localparam int         HoldCycles = 500;

  typedef enum logic [1:0] {SkipBlank, InDigits, DigitsDone} digit_phase_e;

  typedef struct packed {
    logic [ClassW-1:0] label_class;
    logic [ValueW-1:0] field_value;
    logic              check_done;
    logic              check_ok;
    logic [CharW-1:0]  status_char;
  } report_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_data_i;
  logic hold_go;
  int   hold_left;
  int   src_idle_pct;
  int   snk_stall_pct;
  int   errors;

  logic [7:0] line_bytes[$];
  report_t    group_reports[$];

  logic             tariff_srv;
  logic             grp_open;
  logic [1:0]       tabs_seen;
  label_t           lab_chars;
  logic [3:0]       lab_len;
  logic [ValueW-1:0] acc;
  digit_phase_e     digit_phase;
  logic [5:0]       char_sum;
  logic [CharW-1:0] chk_char;
  logic             chk_seen;
  logic [1:0]       val_count;
  logic [CharW-1:0] second_ch;

  tgp_byte_if   byte_if ();
  tgp_result_if res_if ();

  tic_group_parser_checksum dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (byte_if),
    .out_o      (res_if)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic is_blank(input logic [CharW-1:0] c);
    return c == ChSpace || c == ChVt || c == ChFf || c == ChCr;
  endfunction

  task automatic clear_group();
    tabs_seen   = '0;
    lab_chars   = '0;
    lab_len     = '0;
    acc         = '0;
    digit_phase = SkipBlank;
    char_sum    = '0;
    chk_char    = '0;
    chk_seen    = 1'b0;
    val_count   = '0;
    second_ch   = '0;
  endtask

  function automatic logic [ClassW-1:0] label_class_of();
    int   i;
    int   k;
    logic fits;
    logic same;
    for (i = 0; i < NumLabels; i++) begin
      fits = (i == ExactLabel) ? (lab_len == LabelSize[i]) : (lab_len >= LabelSize[i]);
      same = 1'b1;
      for (k = 0; k < LabelSize[i]; k++) begin
        if (lab_chars[k] != LabelText[i][46-8*k -: 7]) same = 1'b0;
      end
      if (fits && same) return ClassW'(i + 1);
    end
    return ClsOther;
  endfunction

  task automatic parse_char(input logic [7:0] b);
    logic [CharW-1:0]  c;
    logic              blank;
    logic              digit;
    logic [31:0]       d;
    logic [ClassW-1:0] cls;
    report_t           r;
    c = b[6:0];
    if (c == ChLf) begin
      grp_open = 1'b1;
      clear_group();
    end else if (c == ChEtx) begin
      grp_open = 1'b0;
    end else if (grp_open) begin
      if (tabs_seen == 2'd2 && !chk_seen) begin
        chk_char = c;
        chk_seen = 1'b1;
      end
      if (c == ChTab) begin
        if (tabs_seen != 2'd3) tabs_seen = tabs_seen + 2'd1;
      end else if (tabs_seen == 2'd0) begin
        if (lab_len < LabelChars) lab_chars[lab_len[LabelIdxW-1:0]] = c;
        if (lab_len != 4'd15) lab_len = lab_len + 4'd1;
        char_sum = char_sum + c[5:0];
      end else if (tabs_seen == 2'd1) begin
        blank = is_blank(c);
        digit = c >= ChZero && c <= ChNine;
        if (!(digit_phase == SkipBlank && blank)) begin
          if (digit_phase == SkipBlank) digit_phase = digit ? InDigits : DigitsDone;
          else if (digit_phase == InDigits && !digit) digit_phase = DigitsDone;
          if (digit_phase == InDigits) begin
            d = 32'(c) - 32'(ChZero);
            if (32'(acc) > (32'(ValueMax) - d) / 10) acc = ValueMax;
            else acc = ValueW'(32'(acc) * 10 + d);
          end
          if (val_count == 2'd0) begin
            val_count = 2'd1;
          end else if (val_count == 2'd1) begin
            second_ch = c;
            val_count = blank ? 2'd2 : 2'd3;
          end else if (val_count == 2'd2 && !blank) begin
            val_count = 2'd3;
          end
        end
        char_sum = char_sum + c[5:0];
      end
      if (c == ChCr) begin
        grp_open = 1'b0;
        cls = label_class_of();
        if (tariff_srv && (cls == ClsLtarf || cls == ClsStge)) cls = ClsOther;
        r.label_class = cls;
        r.field_value = acc;
        r.check_done  = cls >= ClsEast && cls <= ClsSinsti;
        r.check_ok    = chk_seen &&
                        chk_char == CharW'(6'(char_sum + CheckBias)) + CharW'(CheckBase);
        r.status_char = (cls == ClsStge && val_count == 2'd3) ? second_ch : '0;
        group_reports.push_back(r);
      end
    end
  endtask

  function automatic logic [7:0] rand_text();
    if ($urandom_range(19) == 0) return ChStx;
    return 8'($urandom_range(32, 126));
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(2))
      0: return ChSpace;
      1: return ChVt;
      default: return ChFf;
    endcase
  endfunction

  function automatic logic [7:0] rand_digit();
    if ($urandom_range(3) == 0) return ChNine;
    return 8'($urandom_range(ChZero, ChNine));
  endfunction

  task automatic push_char(input logic [7:0] b);
    line_bytes.push_back({$urandom_range(15) == 0, b[6:0]});
  endtask

  task automatic add_chunk();
    logic [7:0] lab[$];
    logic [7:0] val[$];
    logic [7:0] chk;
    logic [5:0] sum;
    int         pick;
    int         k;
    case ($urandom_range(9))
      0: repeat ($urandom_range(1, 6)) line_bytes.push_back(8'($urandom_range(255)));
      1: begin
        push_char(ChLf);
        repeat ($urandom_range(4)) push_char(rand_text());
        push_char(ChEtx);
      end
      default: begin
        pick = $urandom_range(NumLabels);
        if (pick < NumLabels) begin
          for (k = 0; k < LabelSize[pick]; k++) lab.push_back({1'b0, LabelText[pick][46-8*k -: 7]});
        end else begin
          repeat ($urandom_range(17)) lab.push_back(rand_text());
        end
        case ($urandom_range(7))
          0: lab.push_back(rand_text());
          1: if (lab.size() != 0) lab.delete(lab.size() - 1);
          default: ;
        endcase
        if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) val.push_back(rand_blank());
        case ($urandom_range(6))
          0, 1, 2: repeat ($urandom_range(1, 12)) val.push_back(rand_digit());
          3: begin
            repeat ($urandom_range(1, 3)) val.push_back(rand_digit());
            val.push_back(".");
            repeat ($urandom_range(1, 3)) val.push_back(rand_digit());
          end
          4: begin
            val.push_back($urandom_range(1) ? "-" : "+");
            repeat ($urandom_range(1, 4)) val.push_back(rand_digit());
          end
          5: repeat ($urandom_range(1, 4)) val.push_back($urandom_range(2) ? rand_text() : rand_blank());
          default: ;
        endcase
        sum = '0;
        foreach (lab[i]) sum = sum + lab[i][5:0];
        foreach (val[i]) sum = sum + val[i][5:0];
        chk = {1'b0, CharW'(6'(sum + CheckBias)) + CharW'(CheckBase)};
        push_char(ChLf);
        foreach (lab[i]) push_char(lab[i]);
        push_char(ChTab);
        foreach (val[i]) push_char(val[i]);
        case ($urandom_range(9))
          7: begin
            push_char(ChTab);
            push_char({1'b0, CharW'(6'(sum + CheckBias + $urandom_range(1, 63))) +
                       CharW'(CheckBase)});
          end
          8: if ($urandom_range(1)) push_char(ChTab);
          9: begin
            push_char(ChTab);
            if ($urandom_range(1)) begin
              push_char(ChTab);
            end else begin
              push_char(chk);
              push_char(rand_text());
              push_char(ChTab);
            end
          end
          default: begin
            push_char(ChTab);
            push_char(chk);
          end
        endcase
        push_char(ChCr);
      end
    endcase
  endtask

  task automatic settle();
    while (line_bytes.size() != 0 || byte_if.valid || group_reports.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic tariff, input int src_pct, input int snk_pct,
                           input bit long_hold);
    int target;
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= tariff;
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    tariff_srv    = tariff;
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    if (long_hold) hold_go <= 1'b1;
    target = line_bytes.size() + PhaseBytes;
    while (line_bytes.size() < target) add_chunk();
    @(posedge clk_i);
    hold_go <= 1'b0;
    settle();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_if.valid   <= 1'b0;
      byte_if.rx_byte <= '0;
    end else begin
      if (byte_if.valid && byte_if.ready) parse_char(byte_if.rx_byte);
      if (!byte_if.valid || byte_if.ready) begin
        if (line_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          byte_if.valid   <= 1'b1;
          byte_if.rx_byte <= line_bytes.pop_front();
        end else begin
          byte_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) hold_left <= 0;
    else if (hold_go) hold_left <= HoldCycles;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    report_t want;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (group_reports.size() == 0) begin
          $error("result word with no group report pending");
          errors++;
        end else begin
          want = group_reports.pop_front();
          if (res_if.label_class !== want.label_class) begin
            $error("label_class expected %0d, got %0d", want.label_class, res_if.label_class);
            errors++;
          end
          if (res_if.field_value !== want.field_value) begin
            $error("field_value expected %0d, got %0d", want.field_value, res_if.field_value);
            errors++;
          end
          if (res_if.check_done !== want.check_done) begin
            $error("check_done expected %0d, got %0d", want.check_done, res_if.check_done);
            errors++;
          end
          if (res_if.check_ok !== want.check_ok) begin
            $error("check_ok expected %0d, got %0d", want.check_ok, res_if.check_ok);
            errors++;
          end
          if (res_if.status_char !== want.status_char) begin
            $error("status_char expected %0d, got %0d", want.status_char, res_if.status_char);
            errors++;
          end
        end
      end
      res_if.ready <= hold_left == 0 && $urandom_range(99) >= snk_stall_pct;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_data_i      = 1'b0;
    hold_go         = 1'b0;
    src_idle_pct    = 0;
    snk_stall_pct   = 0;
    errors          = 0;
    tariff_srv      = 1'b0;
    grp_open        = 1'b0;
    clear_group();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    line_bytes = '{ChCr, 8'hFF, 8'h00,
                   {1'b1, ChLf}, "E", "A", "S", "T", ChTab, "1", ChTab, "P", ChCr,
                   ChLf, "S", "T", "G", "E", ChTab, " ", "A", ChVt, "B", ChCr,
                   ChLf, ChStx, ChTab, ChTab, ChTab, ChCr, ChEtx};
    settle();
    run_phase(1'b1, 0, 0, 1'b0);
    run_phase(1'b0, 79, 0, 1'b0);
    run_phase(1'b1, 0, 79, 1'b0);
    run_phase(1'b0, 20, 20, 1'b0);
    run_phase(1'b1, 0, 0, 1'b1);
    if (errors == 0) $display("tb_tic_group_parser_checksum: clean");
    else $display("tb_tic_group_parser_checksum: errors");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("tb_tic_group_parser_checksum: errors");
    $finish;
  end

endmodule
